/* hw/rtl/swfb_pkg.sv */
// Shared types, constants and helper functions for the stereo feedback waveshaper.
package swfb_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int CFG_W           = 13;
  localparam int TANH_DEPTH_DEF  = 256;
  localparam int FADE_STEPS_DEF  = 100;
  localparam int DIV_W           = 64;
  localparam int QCNT_W          = 6;

  localparam logic [CFG_W-1:0] Q12_ONE = 13'd4096;

  typedef enum logic [1:0] {
    REG_SHAPE       = 2'd0,
    REG_FEEDBACK    = 2'd1,
    REG_WAVE_SOURCE = 2'd2,
    REG_EFFECT_ON   = 2'd3
  } reg_index_t;

  // Request to the shared divider: quotient bit count is set per use.
  typedef struct packed {
    logic              start;
    logic [QCNT_W-1:0] qbits;
  } div_req_t;

  // Q30 multiply with rounding, elaboration-time use.
  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

endpackage

/* hw/rtl/stereo_feedback_waveshaper.sv */
// Stereo feedback waveshaper: one shared multiplier and one shared divider under a sequencer.
// Each channel may need one 26-bit curve division on the radix-2 divider (skipped for zero or pole).
// Input: one pair at a time; s_axis_tready is high only in the idle state,
//   and a word still waiting on the output holds the sequencer before it returns there.
// Reset: defaults load, state clears, then the tanh table is rebuilt.
module stereo_feedback_waveshaper
  import swfb_pkg::*;
#(
  parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
  parameter int FADE_STEPS       = FADE_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*SAMPLE_W-1:0] s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SAMPLE_W-1:0] m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int KW = $clog2(FADE_STEPS + 1);
  localparam int TW = 31;   // Q30 table word, at most 1.0

  // Crossfade division by FADE_STEPS: reciprocal estimate, then one correction step.
  localparam int          FADE_SHIFT = KW + 24;
  localparam logic [31:0] FADE_RECIP = 32'((64'd1 << FADE_SHIFT) / 64'(FADE_STEPS));

  // tanh(h) for the table step, from its odd series.
  localparam logic [63:0] TH_H  = ((64'd1 << 33) + 64'(TANH_TABLE_DEPTH / 2))
                                  / 64'(TANH_TABLE_DEPTH);
  localparam logic [63:0] TH_H2 = mul_q30(TH_H, TH_H);
  localparam logic [63:0] TH_P2 = mul_q30(TH_H2, TH_H2);
  localparam logic [63:0] TH_P3 = mul_q30(TH_P2, TH_H2);
  localparam logic [63:0] TH_P4 = mul_q30(TH_P3, TH_H2);
  localparam logic [63:0] TH_POLY = 64'd1073741824 + 64'd2 * TH_P2 / 64'd15
                                  + 64'd62 * TH_P4 / 64'd2835 - TH_H2 / 64'd3
                                  - 64'd17 * TH_P3 / 64'd315;
  localparam logic [63:0] TH_STEP = mul_q30(TH_H, TH_POLY);

  localparam logic [23:0] ENV_MAX   = 24'd8388607;
  localparam logic [23:0] ENV_DECAY = 24'd8389;

  typedef enum logic [5:0] {
    ST_CLR, ST_BMUL, ST_BDIV, ST_BWAIT,
    ST_IDLE, ST_T1, ST_T2, ST_T3, ST_T4, ST_D,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_CWAIT,
    ST_G1, ST_G2, ST_G3, ST_G4,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
    ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] shape;
  logic [CFG_W-1:0] feedback;
  logic             wave_source;
  logic             effect_on;
  logic [CFG_W-1:0] cfg_clamped;

  // Persistent state
  logic [22:0]        peak_envelope;
  logic signed [23:0] last_left_wave;
  logic [KW-1:0]      crossfade_step;

  // Working registers
  logic signed [23:0] xl, xr, src, wet, left_res, right_res;
  logic               ch;
  logic signed [37:0] acc, t35;
  logic signed [31:0] d;
  logic signed [55:0] n;
  logic signed [33:0] dq;
  logic               sgn;
  logic [30:0]        mag;
  logic [43:0]        pos;
  logic [TW-1:0]      t0, tv, diff, tcur;
  logic [AW-1:0]      bk;
  logic signed [39:0] facc;
  logic [35:0]        fu;
  logic [24:0]        fq;

  // Shared multiplier
  logic signed [37:0] ma;
  logic signed [31:0] mb;
  logic signed [69:0] prod;

  // Table memory
  logic [TW-1:0] tanh_mem [0:TANH_TABLE_DEPTH];
  logic [TW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [TW-1:0] wdata;
  logic          mem_we;

  // Divider
  div_req_t         div_req;
  logic [DIV_W-1:0] div_dividend, div_divisor, div_q;
  logic             div_done;

  // Combinational helpers
  logic signed [23:0] xc;
  logic               xneg;
  logic [23:0]        ax;
  logic signed [25:0] two_a_m1;
  logic signed [56:0] den;
  logic [54:0]        nm;
  logic [33:0]        dm;
  logic               negq;
  logic               pole;
  logic [12:0]        inv_fb;
  logic [11:0]        gain1;
  logic [13:0]        gain2;
  logic signed [69:0] prod_sh21;
  logic [17:0]        idx;
  logic               idx_sat;
  logic signed [23:0] in_left;
  logic [23:0]        abs_left;
  logic [22:0]        env_new;
  logic signed [39:0] fade_sum;
  logic signed [69:0] prod_shf;
  logic [35:0]        fade_rem;
  logic               fade_adj;
  logic [24:0]        fq_fix;
  logic [46:0]        scaled;
  logic [23:0]        out_mag;
  logic signed [26:0] fade_q;
  logic signed [23:0] fade_sat;
  logic [TW:0]        bnum;
  logic [63:0]        bden;
  logic [63:0]        prod_rnd;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign cfg_clamped   = (cfg_data > Q12_ONE) ? Q12_ONE : cfg_data;

  assign xc       = ch ? xr : xl;
  assign xneg     = xc[23];
  assign ax       = xneg ? 24'(-{xc[23], xc}) : 24'(xc);
  assign two_a_m1 = $signed({1'b0, ax, 1'b0}) - 26'sd8388608;
  assign den      = $signed(prod[56:0]) + $signed({3'd0, 24'(24'd8388608 - ax), 30'd0});
  assign nm       = n[55] ? 55'(-n) : 55'(n);
  assign dm       = dq[33] ? 34'(-dq) : 34'(dq);
  assign negq     = n[55] ^ dq[33];
  assign pole     = (dm == '0) || ({5'd0, nm} >= {dm, 26'd0});
  assign inv_fb   = Q12_ONE - feedback;
  assign gain1    = 12'(13'd2304 - shape);
  assign gain2    = 14'd4096 + {feedback, 1'b0};
  assign prod_sh21 = prod >>> 21;
  assign idx      = pos[43:26];
  assign idx_sat  = (idx >= 18'(TANH_TABLE_DEPTH));
  assign scaled   = prod[46:0] + 47'd4194304;
  assign out_mag  = scaled[46:23];

  // Envelope follower input: |left| saturated to full scale
  assign in_left  = s_axis_tdata[SAMPLE_W-1:0];
  assign abs_left = in_left[23] ? ((in_left == 24'sh800000) ? ENV_MAX : 24'(-in_left))
                                : 24'(in_left);
  always_comb begin
    if (abs_left[22:0] > peak_envelope) begin
      env_new = abs_left[22:0];
    end else if ({1'b0, peak_envelope} > ENV_DECAY) begin
      env_new = peak_envelope - ENV_DECAY[22:0];
    end else begin
      env_new = '0;
    end
  end

  // Crossfade: offset sum, reciprocal quotient estimate, then fix it up by the remainder
  assign fade_sum = facc + 40'(prod) + 40'(FADE_STEPS) * 40'sd8388608;
  assign prod_shf = prod >>> FADE_SHIFT;
  assign fade_rem = fu - prod[35:0];
  assign fade_adj = (fade_rem >= 36'(FADE_STEPS));
  assign fq_fix   = fq + 25'(fade_adj);
  assign fade_q   = $signed({2'b0, fq_fix}) - 27'sd8388608;
  assign fade_sat = (fade_q > 27'sd8388607)  ? 24'sh7fffff :
                    (fade_q < -27'sd8388608) ? 24'sh800000 : 24'(fade_q);

  // Table build recurrence: T' = ((T+th)<<30 + den/2) / den, den = 1 + T*th
  assign prod_rnd = prod[63:0] + 64'd536870912;
  assign bden     = 64'd1073741824 + (prod_rnd >> 30);
  assign bnum     = {1'b0, tcur} + (TW+1)'(TH_STEP);

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_BMUL: begin ma = {7'd0, tcur};  mb = 32'(TH_STEP); end
      ST_T1:   begin ma = {25'd0, inv_fb}; mb = {19'd0, shape}; end
      ST_T2:   begin ma = {{14{src[23]}}, src}; mb = {19'd0, feedback}; end
      ST_T4:   begin ma = t35; mb = 32'sd64881; end
      ST_C0:   begin ma = {{6{d[31]}}, d}; mb = {8'd0, ax}; end
      ST_C1:   begin ma = {{6{d[31]}}, d}; mb = {{6{two_a_m1[25]}}, two_a_m1}; end
      ST_G1:   begin ma = {7'd0, mag}; mb = {20'd0, gain1}; end
      ST_G3:   begin ma = {7'd0, mag}; mb = {18'd0, gain2}; end
      ST_P1:   begin ma = {7'd0, mag}; mb = 32'(TANH_TABLE_DEPTH); end
      ST_P6:   begin ma = {7'd0, diff}; mb = {6'd0, pos[25:0]}; end
      ST_P8:   begin ma = {7'd0, tv};   mb = 32'sd58982; end
      ST_F1:   begin ma = {{14{wet[23]}}, wet}; mb = 32'(crossfade_step); end
      ST_F2:   begin ma = {{14{xc[23]}}, xc}; mb = 32'(FADE_STEPS) - 32'(crossfade_step); end
      ST_F4:   begin ma = {2'd0, fu};  mb = FADE_RECIP; end
      ST_F6:   begin ma = {13'd0, fq}; mb = 32'(FADE_STEPS); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Divider request select
  always_comb begin
    div_req.start = 1'b0;
    div_req.qbits = 6'd26;
    div_dividend  = '0;
    div_divisor   = 64'd1;
    case (state)
      ST_BDIV: begin
        div_req.start = 1'b1;
        div_req.qbits = 6'd32;
        div_dividend  = {bnum, 30'd0} + (bden >> 1);
        div_divisor   = bden;
      end
      ST_C3: begin
        div_req.start = (n != '0) && !pole;
        div_dividend  = 64'(nm);
        div_divisor   = 64'(dm);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  swfb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Table memory ports
  always_comb begin
    case (state)
      ST_P3:   raddr = idx_sat ? AW'(TANH_TABLE_DEPTH) : AW'(idx);
      ST_P4:   raddr = AW'(idx) + 1'b1;
      default: raddr = '0;
    endcase
    mem_we = (state == ST_CLR) || ((state == ST_BWAIT) && div_done);
    waddr  = (state == ST_CLR) ? '0 : bk + 1'b1;
    wdata  = (state == ST_CLR) ? '0 : div_q[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tanh_mem[waddr] <= wdata;
    end
    rdata <= tanh_mem[raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shape       <= 13'd2048;
      feedback    <= '0;
      wave_source <= 1'b0;
      effect_on   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SHAPE:       shape       <= cfg_clamped;
        REG_FEEDBACK:    feedback    <= cfg_clamped;
        REG_WAVE_SOURCE: wave_source <= cfg_data[0];
        REG_EFFECT_ON:   effect_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLR;
      m_axis_tvalid  <= 1'b0;
      peak_envelope  <= '0;
      last_left_wave <= '0;
      crossfade_step <= '0;
      ch             <= 1'b0;
      bk             <= '0;
      tcur           <= '0;
    end else begin
      // Drop the output word once taken; the output state reloads it itself
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        // Rebuild the tanh table, one division per entry
        ST_CLR: begin
          tcur  <= '0;
          bk    <= '0;
          state <= ST_BMUL;
        end
        ST_BMUL: state <= ST_BDIV;
        ST_BDIV: state <= ST_BWAIT;
        ST_BWAIT: begin
          if (div_done) begin
            tcur <= div_q[TW-1:0];
            if (bk == AW'(TANH_TABLE_DEPTH - 1)) begin
              state <= ST_IDLE;
            end else begin
              bk    <= bk + 1'b1;
              state <= ST_BMUL;
            end
          end
        end

        // Take a pair; pick the feedback source, advancing the envelope only when it is the source
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            xl  <= s_axis_tdata[SAMPLE_W-1:0];
            xr  <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            ch  <= 1'b0;
            if ((feedback != '0) && wave_source) begin
              src <= last_left_wave;
            end else if (feedback != '0) begin
              peak_envelope <= env_new;
              src           <= {1'b0, env_new};
            end else begin
              src <= '0;
            end
            state <= ST_T1;
          end
        end
        ST_T1: state <= ST_T2;
        ST_T2: begin
          acc   <= {prod[26:0], 11'd0};
          state <= ST_T3;
        end
        ST_T3: begin
          t35   <= acc + prod[37:0];
          state <= ST_T4;
        end
        ST_T4: state <= ST_D;
        ST_D: begin
          d     <= prod_sh21[31:0] + 32'sd5368709;
          state <= ST_C0;
        end

        // Rational curve on |x|
        ST_C0: state <= ST_C1;
        ST_C1: begin
          n     <= prod[55:0];
          state <= ST_C2;
        end
        ST_C2: begin
          dq    <= den[56:23];
          state <= ST_C3;
        end
        ST_C3: begin
          if (n == '0) begin
            mag   <= '0;
            sgn   <= 1'b0;
            state <= ST_G1;
          end else if (pole) begin
            sgn   <= negq ^ xneg;
            mag   <= 31'd67108864;
            state <= ST_G1;
          end else begin
            sgn   <= negq ^ xneg;
            state <= ST_CWAIT;
          end
        end
        ST_CWAIT: begin
          if (div_done) begin
            mag   <= {5'd0, div_q[25:0]};
            state <= ST_G1;
          end
        end

        // Gains, applied to the magnitude
        ST_G1: state <= ST_G2;
        ST_G2: begin
          if (shape < 13'd2048) begin
            mag <= prod[38:8];
          end
          state <= ST_G3;
        end
        ST_G3: state <= ST_G4;
        ST_G4: begin
          if (wave_source) begin
            mag <= prod[42:12];
          end
          state <= ST_P1;
        end

        // tanh by table with linear interpolation
        ST_P1: state <= ST_P2;
        ST_P2: begin
          pos   <= prod[43:0];
          state <= ST_P3;
        end
        ST_P3: state <= ST_P4;
        ST_P4: begin
          t0 <= rdata;
          if (idx_sat) begin
            tv    <= rdata;
            state <= ST_P8;
          end else begin
            state <= ST_P5;
          end
        end
        ST_P5: begin
          diff  <= rdata - t0;
          state <= ST_P6;
        end
        ST_P6: state <= ST_P7;
        ST_P7: begin
          tv    <= t0 + prod[56:26];
          state <= ST_P8;
        end
        ST_P8: state <= ST_P9;
        ST_P9: begin
          wet   <= sgn ? 24'(-out_mag) : 24'(out_mag);
          state <= ST_F1;
        end

        // Crossfade with the dry sample
        ST_F1: state <= ST_F2;
        ST_F2: begin
          facc  <= 40'(prod);
          state <= ST_F3;
        end
        ST_F3: begin
          fu    <= fade_sum[39] ? '0 : fade_sum[35:0];
          state <= ST_F4;
        end
        ST_F4: state <= ST_F5;
        ST_F5: begin
          fq    <= prod_shf[24:0];
          state <= ST_F6;
        end
        ST_F6: state <= ST_F7;
        ST_F7: begin
          if (!ch) begin
            left_res       <= fade_sat;
            last_left_wave <= wet;
            ch             <= 1'b1;
            state          <= ST_C0;
          end else begin
            right_res <= fade_sat;
            state     <= ST_OUT;
          end
        end

        // Hold until the output register is free, then step the fade toward wet or dry per effect_on
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {right_res, left_res};
            m_axis_tvalid <= 1'b1;
            if (effect_on && (crossfade_step < KW'(FADE_STEPS))) begin
              crossfade_step <= crossfade_step + 1'b1;
            end else if (!effect_on && (crossfade_step != '0)) begin
              crossfade_step <= crossfade_step - 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/swfb_div.sv */
// Restoring radix-2 divider shared by the table build and the curve.
module swfb_div
  import swfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  sh;
  logic [DIV_W-1:0]  dsr;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic [DIV_W-1:0]  rem_shift;
  logic              fits;

  // Caller guarantees the quotient fits in qbits, so the top part is already below divisor.
  assign rem_shift = {rem[DIV_W-2:0], sh[DIV_W-1]};
  assign fits      = (rem_shift >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == QCNT_W'(1));
      if (req.start) begin
        rem      <= dividend >> req.qbits;
        sh       <= dividend << (7'd64 - {1'b0, req.qbits});
        dsr      <= divisor;
        cnt      <= req.qbits;
        quotient <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? (rem_shift - dsr) : rem_shift;
        quotient <= {quotient[DIV_W-2:0], fits};
        sh       <= {sh[DIV_W-2:0], 1'b0};
        cnt      <= cnt - 1'b1;
        if (cnt == QCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* verif/tb.sv */
// Testbench for the stereo feedback waveshaper: directed and random sample pairs, scoreboard check.
module tb;
  import swfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TDEPTH      = 256;
  localparam int FADE_N      = 100;
  localparam int DRAIN_WAIT  = 300;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata = '0;    // [23:0] left_in, [47:24] right_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;         // [23:0] left_out, [47:24] right_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_index_t            cfg_index = REG_SHAPE;
  logic [CFG_W-1:0]      cfg_data = '0;

  stereo_feedback_waveshaper uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the configuration and the per-sample state.
  int unsigned     shape_q12, fb_q12, use_wave, fx_on;
  int unsigned     env_peak, fade_pos;
  longint          prev_left_wet;
  bit [63:0]       tanh_pts [0:TDEPTH];

  stereo_pair_t    expected_pairs [$];
  int              mismatch_count = 0;
  int              pairs_sent = 0, pairs_checked = 0, cfg_phases = 0;
  int              send_idle_pct = 0, recv_stall_pct = 0;
  int              quiet_cycles = 0;

  function automatic bit [63:0] q30_mul_round(bit [63:0] a, bit [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Rebuild the interpolation table the way the block does at reset.
  function automatic void build_tanh_points();
    bit [63:0] h, h2, p2, p3, p4, poly, th, num, den;
    h    = ((64'd1 << 33) + TDEPTH / 2) / TDEPTH;
    h2   = q30_mul_round(h, h);
    p2   = q30_mul_round(h2, h2);
    p3   = q30_mul_round(p2, h2);
    p4   = q30_mul_round(p3, h2);
    poly = (64'd1 << 30) + 2 * p2 / 15 + 62 * p4 / 2835 - h2 / 3 - 17 * p3 / 315;
    th   = q30_mul_round(h, poly);
    tanh_pts[0] = 0;
    for (int k = 0; k < TDEPTH; k++) begin
      num = (tanh_pts[k] + th) << 30;
      den = (64'd1 << 30) + q30_mul_round(tanh_pts[k], th);
      tanh_pts[k+1] = (num + den / 2) / den;
    end
  endfunction

  // Odd rational curve on a Q23 magnitude; pole and large quotients clamp at 8.0.
  function automatic longint shape_curve(longint a, longint d);
    longint    n, den, dq;
    bit [63:0] nm, dm, mag;
    bit        neg;
    n   = d * a;
    den = d * (2 * a - (64'sd1 <<< 23)) + (((64'sd1 <<< 23) - a) <<< 30);
    dq  = den >>> 23;
    if (n == 0) return 0;
    nm  = (n < 0) ? -n : n;
    dm  = (dq < 0) ? -dq : dq;
    neg = (n < 0) != (dq < 0);
    if (dm == 0 || nm >= (dm << 26)) mag = 64'd1 << 26;
    else mag = nm / dm;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint wet_sample(longint x, longint d);
    longint    y;
    bit [63:0] mag, pos, idx, tv, res;
    bit        neg;
    y = shape_curve((x < 0) ? -x : x, d);
    if (x < 0) y = -y;
    neg = y < 0;
    mag = neg ? -y : y;
    if (shape_q12 < 2048) mag = (mag * (2304 - shape_q12)) >> 8;
    if (use_wave != 0) mag = (mag * (4096 + 2 * fb_q12)) >> 12;
    pos = mag * TDEPTH;
    idx = pos >> 26;
    if (idx >= TDEPTH) tv = tanh_pts[TDEPTH];
    else tv = tanh_pts[idx] +
              (((tanh_pts[idx+1] - tanh_pts[idx]) * (pos & ((64'd1 << 26) - 1))) >> 26);
    res = (tv * 58982 + (64'd1 << 22)) >> 23;
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] blend_dry(longint wet, longint dry);
    longint k, u, q;
    k = fade_pos;
    u = wet * k + dry * (FADE_N - k) + longint'(FADE_N) * (64'sd1 <<< 23);
    if (u < 0) u = 0;
    q = u / FADE_N - (64'sd1 <<< 23);
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the predictor by one input pair and return the shaped pair.
  function automatic stereo_pair_t shape_pair(logic signed [SAMPLE_W-1:0] xl_in,
                                              logic signed [SAMPLE_W-1:0] xr_in);
    longint       xl, xr, src, t35, d, wl, wr;
    int unsigned  mag_l;
    stereo_pair_t res;
    xl  = xl_in;
    xr  = xr_in;
    src = 0;
    if (fb_q12 > 0) begin
      if (use_wave != 0) begin
        src = prev_left_wet;
      end else begin
        mag_l = 32'((xl < 0) ? -xl : xl);
        if (mag_l > 8388607) mag_l = 8388607;
        if (mag_l > env_peak) env_peak = mag_l;
        else if (env_peak > 8389) env_peak -= 8389;
        else env_peak = 0;
        src = env_peak;
      end
    end
    t35 = (longint'(4096 - fb_q12) * shape_q12 <<< 11) + longint'(fb_q12) * src;
    d   = ((t35 * 64881) >>> 21) + 5368709;
    wl  = wet_sample(xl, d);
    wr  = wet_sample(xr, d);
    prev_left_wet = wl;
    res.left  = blend_dry(wl, xl);
    res.right = blend_dry(wr, xr);
    if (fx_on != 0 && fade_pos < FADE_N) fade_pos++;
    else if (fx_on == 0 && fade_pos > 0) fade_pos--;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drive one sample pair; keep tvalid high across back-to-back words.
  task automatic send_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_pairs.push_back(shape_pair(l, r));
    pairs_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drain outstanding words, then let the sequencer settle before a register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write all four registers back to back; values above 4096 clamp in the predictor.
  task automatic write_regs(logic [CFG_W-1:0] shp, logic [CFG_W-1:0] fb, bit src, bit on);
    logic [CFG_W-1:0] vals [4];
    reg_index_t       idx [4];
    vals = '{shp, fb, CFG_W'(src), CFG_W'(on)};
    idx  = '{REG_SHAPE, REG_FEEDBACK, REG_WAVE_SOURCE, REG_EFFECT_ON};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    shape_q12 = (shp > 4096) ? 4096 : shp;
    fb_q12    = (fb > 4096) ? 4096 : fb;
    use_wave  = src;
    fx_on     = on;
    cfg_phases++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return SAMPLE_W'($urandom_range(255) - 128);
      1:       return ($urandom_range(1) != 0) ? SAMPLE_W'(24'sh7FFFFF - $urandom_range(64))
                                               : SAMPLE_W'(24'sh800000 + $urandom_range(64));
      2:       return SAMPLE_W'($urandom_range(4194303) - 2097152);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Reset defaults, sample extremes and zero input.
  task automatic test_defaults();
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sh800000, 24'sh7FFFFF);
    send_pair(24'sd1, -24'sd1);
    send_pair(24'sh555555, 24'shAAAAAA);
  endtask

  // Out-of-range register values, envelope saturation, decay and hold.
  task automatic test_limits_and_envelope();
    write_regs(13'h1FFF, 13'd5000, 1'b0, 1'b1);
    send_pair(24'sh800000, 24'sd12345);
    send_pair(24'sd0, 24'sh7FFFFF);
    send_pair(24'sd100, -24'sd100);
    write_regs(13'd0, 13'd2048, 1'b0, 1'b1);
    send_pair(24'sh7FFFFF, 24'sd0);
    send_pair(24'sd0, 24'sh400000);
    write_regs(13'd0, 13'd0, 1'b0, 1'b1);
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sd3, 24'sd0);
  endtask

  // Previous-output feedback with full gain, fading back toward dry.
  task automatic test_wave_feedback();
    write_regs(13'd0, 13'd4096, 1'b1, 1'b0);
    send_pair(24'sh800000, 24'sh7FFFFF);
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(-24'sd4000000, 24'sd4000000);
    send_pair(24'sd0, 24'sd0);
    write_regs(13'd4096, 13'd4096, 1'b1, 1'b1);
    send_pair(24'sh400000, -24'sd1);
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, logic [CFG_W-1:0] shp,
                                   logic [CFG_W-1:0] fb, bit src, bit on, int n);
    write_regs(shp, fb, src, on);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) send_pair(pick_sample(), pick_sample());
  endtask

  // Receiver stalls and the scoreboard compare.
  always @(posedge clk) begin
    stereo_pair_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        want = expected_pairs.pop_front();
        if (m_axis_tdata[23:0] !== want.left)
          report_mismatch($sformatf("left_out got %0d expected %0d",
                                    $signed(m_axis_tdata[23:0]), want.left));
        if (m_axis_tdata[47:24] !== want.right)
          report_mismatch($sformatf("right_out got %0d expected %0d",
                                    $signed(m_axis_tdata[47:24]), want.right));
        pairs_checked++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any accepted word on any channel counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    build_tanh_points();
    shape_q12 = 2048; fb_q12 = 0; use_wave = 0; fx_on = 1;
    env_peak = 0; prev_left_wet = 0; fade_pos = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_limits_and_envelope();
    test_wave_feedback();

    test_random_phase(0, 0, 13'd2048, 13'd0, 1'b0, 1'b1, 80);
    test_random_phase(63, 0, 13'd0, 13'd4096, 1'b0, 1'b1, 80);
    test_random_phase(0, 63, 13'd4096, 13'd2000, 1'b1, 1'b1, 80);
    test_random_phase(32, 32, CFG_W'($urandom_range(4096)), CFG_W'($urandom_range(4096)),
                      1'b0, 1'b0, 80);
    test_random_phase(0, 0, CFG_W'($urandom_range(4096)), CFG_W'($urandom_range(4096)),
                      1'b1, 1'b1, 80);
    test_random_phase(63, 0, 13'd1000, 13'd4096, 1'b1, 1'b0, 75);
    test_random_phase(0, 63, CFG_W'($urandom_range(8191)), CFG_W'($urandom_range(8191)),
                      1'b0, 1'b1, 75);
    test_random_phase(32, 32, 13'd100, 13'd300, 1'b1, 1'b1, 75);

    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d sample pairs over %0d register settings, checked %0d output words",
             pairs_sent, cfg_phases, pairs_checked);
    $display("Covered envelope and previous-output feedback, gain stages, fades both ways");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* stereo_feedback_waveshaper.f */
hw/rtl/swfb_pkg.sv
hw/rtl/swfb_div.sv
hw/rtl/stereo_feedback_waveshaper.sv
verif/tb.sv
